### hdl/radtxt_pkg.sv
// Shared types and constants for the signed integer to radix text converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package radtxt_pkg;

	// Field and register widths fixed by the interface
	localparam int CHAR_W      = 8;
	localparam int DIGIT_W     = 4;
	localparam int LEN_W       = 5;
	localparam int REM_W       = 5;
	localparam int ALPHA_SLOTS = 16;
	localparam int ALPHA_W     = ALPHA_SLOTS * CHAR_W;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 64;

	// Quotient bits resolved per divider cycle
	localparam int DIV_STEP_BITS = 8;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_RADIX_LENGTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_HIGH = 2'd2;

	// Character codes
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;
	localparam logic [CHAR_W-1:0] CH_LOW   = 8'd33;
	localparam logic [CHAR_W-1:0] CH_HIGH  = 8'd127;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic step;
		logic emit_bad;
		logic emit_sign;
		logic emit_digit;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic div_done;
		logic neg;
		logic out_free;
		logic last_digit;
	} status_t;

endpackage

`default_nettype wire

### hdl/radtxt_cfg.sv
// Configuration registers and alphabet validity check.
// Depends on radtxt_pkg.
`default_nettype none

module radtxt_cfg #(
	parameter int MAX_RADIX = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_valid,
	input  wire logic [radtxt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [radtxt_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic [radtxt_pkg::LEN_W-1:0]              radix_length,
	output logic [radtxt_pkg::ALPHA_W-1:0]            alphabet,
	output logic                                      alpha_ok
);
	import radtxt_pkg::*;

	logic [LEN_W-1:0]      len_q;
	logic [CFG_DATA_W-1:0] low_q;
	logic [CFG_DATA_W-1:0] high_q;
	logic [ALPHA_W-1:0]    alpha;
	logic [CHAR_W-1:0]     c;
	logic                  ok;
	logic                  ok_q;

	// Write registers; unknown indexes drop the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			low_q  <= '0;
			high_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_RADIX_LENGTH:  len_q  <= cfg_data[LEN_W-1:0];
				REG_ALPHABET_LOW:  low_q  <= cfg_data;
				REG_ALPHABET_HIGH: high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign alpha = {high_q, low_q};

	// Check length, character range, sign characters and duplicates
	always_comb begin
		ok = (len_q >= LEN_W'(2)) && (len_q <= LEN_W'(MAX_RADIX));
		c  = '0;
		for (int a = 0; a < ALPHA_SLOTS; a++) begin
			if (LEN_W'(a) < len_q) begin
				c = alpha[a*CHAR_W +: CHAR_W];
				if (c < CH_LOW || c > CH_HIGH || c == CH_PLUS || c == CH_MINUS)
					ok = 1'b0;
				for (int b = a + 1; b < ALPHA_SLOTS; b++) begin
					if (LEN_W'(b) < len_q && alpha[b*CHAR_W +: CHAR_W] == c)
						ok = 1'b0;
				end
			end
		end
	end

	// Hold the verdict in a register; read in the cycle after an item arrives
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q <= 1'b0;
		end else begin
			ok_q <= ok;
		end
	end

	assign radix_length = len_q;
	assign alphabet     = alpha;
	assign alpha_ok     = ok_q;

endmodule

`default_nettype wire

### hdl/radtxt_ctrl.sv
// Controller state machine: check, divide, then emit sign and digits, or an error beat for a bad alphabet.
// Depends on radtxt_pkg; drives commands to radtxt_dp.
`default_nettype none

module radtxt_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  alpha_ok,
	input  wire radtxt_pkg::status_t   status,
	output radtxt_pkg::cmd_t           cmd
);
	import radtxt_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_CHECK  = 6'b000010,
		ST_DIVIDE = 6'b000100,
		ST_SIGN   = 6'b001000,
		ST_DIGIT  = 6'b010000,
		ST_BAD    = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = alpha_ok ? ST_DIVIDE : ST_BAD;
			end
			ST_DIVIDE: begin
				cmd.step = 1'b1;
				if (status.div_done)
					state_d = status.neg ? ST_SIGN : ST_DIGIT;
			end
			ST_SIGN: begin
				if (status.out_free) begin
					cmd.emit_sign = 1'b1;
					state_d       = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (status.out_free) begin
					cmd.emit_digit = 1'b1;
					if (status.last_digit)
						state_d = ST_IDLE;
				end
			end
			ST_BAD: begin
				if (status.out_free) begin
					cmd.emit_bad = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

`default_nettype wire

### hdl/radtxt_dp.sv
// Datapath: magnitude divider, digit buffer, read pointer and output register.
// Depends on radtxt_pkg; commanded by radtxt_ctrl.
`default_nettype none

module radtxt_dp #(
	parameter int VALUE_BITS = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic signed [VALUE_BITS-1:0]       number,
	input  wire logic [radtxt_pkg::LEN_W-1:0]       radix_length,
	input  wire logic [radtxt_pkg::ALPHA_W-1:0]     alphabet,
	input  wire radtxt_pkg::cmd_t                   cmd,
	output radtxt_pkg::status_t                     status,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [radtxt_pkg::CHAR_W-1:0]           character,
	output logic                                    last_char,
	output logic                                    bad_alphabet
);
	import radtxt_pkg::*;

	localparam int DIV_CYC = (VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
	localparam int DW      = DIV_CYC * DIV_STEP_BITS;
	localparam int BC_W    = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
	localparam int CNT_W   = $clog2(VALUE_BITS + 1);
	localparam int PTR_W   = $clog2(VALUE_BITS);

	logic [DW-1:0]         div_q;
	logic [DIGIT_W-1:0]    rem_q;
	logic [BC_W-1:0]       bcnt_q;
	logic [CNT_W-1:0]      count_q;
	logic [PTR_W-1:0]      rptr_q;
	logic                  neg_q;
	logic [DIGIT_W-1:0]    buf_q [VALUE_BITS];

	logic [VALUE_BITS-1:0]    mag;
	logic [REM_W-1:0]         r;
	logic [DIV_STEP_BITS-1:0] qbits;
	logic [DW-1:0]            q_next;
	logic                     last_cyc;
	logic [DIGIT_W-1:0]       digit;
	logic [CHAR_W-1:0]        digit_char;
	logic                     out_free;
	logic                     out_valid_q;
	logic [CHAR_W-1:0]        char_q;
	logic                     last_q;
	logic                     bad_q;

	// Magnitude of the two's complement input, unsigned
	assign mag = number[VALUE_BITS-1] ? (~number + VALUE_BITS'(1)) : number;

	// One divider cycle: resolve a byte of quotient bits by restoring steps
	always_comb begin
		r     = {1'b0, rem_q};
		qbits = '0;
		for (int i = 0; i < DIV_STEP_BITS; i++) begin
			r = {r[REM_W-2:0], div_q[DW-1-i]};
			if (r >= radix_length) begin
				r = r - radix_length;
				qbits[DIV_STEP_BITS-1-i] = 1'b1;
			end
		end
		q_next = (div_q << DIV_STEP_BITS) | DW'(qbits);
	end

	assign last_cyc = (bcnt_q == BC_W'(DIV_CYC - 1));

	// Control registers of the divider and buffer pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			bcnt_q  <= '0;
			count_q <= '0;
			rptr_q  <= '0;
			neg_q   <= 1'b0;
		end else if (cmd.load) begin
			rem_q   <= '0;
			bcnt_q  <= '0;
			count_q <= '0;
			neg_q   <= number[VALUE_BITS-1];
		end else if (cmd.step) begin
			if (last_cyc) begin
				rem_q   <= '0;
				bcnt_q  <= '0;
				count_q <= count_q + CNT_W'(1);
				rptr_q  <= count_q[PTR_W-1:0];
			end else begin
				rem_q  <= r[DIGIT_W-1:0];
				bcnt_q <= bcnt_q + BC_W'(1);
			end
		end else if (cmd.emit_digit) begin
			rptr_q <= rptr_q - PTR_W'(1);
		end
	end

	// Dividend shift register and digit buffer
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			div_q <= DW'(mag);
		end else if (cmd.step) begin
			div_q <= q_next;
			if (last_cyc)
				buf_q[count_q[PTR_W-1:0]] <= r[DIGIT_W-1:0];
		end
	end

	// Map the buffered digit through the alphabet
	assign digit      = buf_q[rptr_q];
	assign digit_char = alphabet[{digit, 3'b000} +: CHAR_W];

	// Output register: load on emit, drop valid once the beat is taken
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_bad || cmd.emit_sign || cmd.emit_digit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_bad) begin
			char_q <= CH_NONE;
			last_q <= 1'b1;
			bad_q  <= 1'b1;
		end else if (cmd.emit_sign) begin
			char_q <= CH_MINUS;
			last_q <= 1'b0;
			bad_q  <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= digit_char;
			last_q <= (rptr_q == '0);
			bad_q  <= 1'b0;
		end
	end

	assign status.div_done   = last_cyc &&
		(q_next == '0 || count_q == CNT_W'(VALUE_BITS - 1));
	assign status.neg        = neg_q;
	assign status.out_free   = out_free;
	assign status.last_digit = (rptr_q == '0);

	assign out_valid    = out_valid_q;
	assign character    = char_q;
	assign last_char    = last_q;
	assign bad_alphabet = bad_q;

	// Never overwrite a beat that is still held
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_bad || cmd.emit_sign || cmd.emit_digit) |-> out_free)
		else $error("emit while output register is held");

	// At most one emit command at a time
	a_emit_one: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.emit_bad, cmd.emit_sign, cmd.emit_digit}))
		else $error("conflicting emit commands");

	// Buffer never overflows its depth
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (count_q < CNT_W'(VALUE_BITS)))
		else $error("digit buffer overflow");

	// An error beat always closes its text
	a_bad_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && bad_q) |-> last_q)
		else $error("error beat without last_char");

endmodule

`default_nettype wire

### hdl/signed_integer_to_radix_text_core.sv
// Top level of the signed integer to radix text converter.
// Depends on radtxt_pkg, radtxt_cfg, radtxt_ctrl and radtxt_dp.
//
//   Channel  Direction  Handshake              Payload
//   in       sink       in_valid / in_stall    number
//   out      source     out_valid / out_stall  character, last_char, bad_alphabet
//   cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item at a time: the alphabet is checked first, then the divider works out
// each digit (eight restoring steps a cycle), then the characters are emitted.
// Output stalls hold the emit phase; the next item is taken while the final beat
// still waits. Reset clears configuration to zero.
`default_nettype none

module signed_integer_to_radix_text_core #(
	parameter int MAX_RADIX  = 16,
	parameter int VALUE_BITS = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [VALUE_BITS-1:0]        number,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [radtxt_pkg::CHAR_W-1:0]            character,
	output logic                                     last_char,
	output logic                                     bad_alphabet,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [radtxt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [radtxt_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import radtxt_pkg::*;

	logic [LEN_W-1:0]   radix_length;
	logic [ALPHA_W-1:0] alphabet;
	logic               alpha_ok;
	cmd_t               cmd;
	status_t            status;

	// Configuration always takes a beat
	assign cfg_ready = 1'b1;

	radtxt_cfg #(
		.MAX_RADIX (MAX_RADIX)
	) u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.radix_length (radix_length),
		.alphabet     (alphabet),
		.alpha_ok     (alpha_ok)
	);

	radtxt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.alpha_ok (alpha_ok),
		.status   (status),
		.cmd      (cmd)
	);

	radtxt_dp #(
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.number       (number),
		.radix_length (radix_length),
		.alphabet     (alphabet),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.character    (character),
		.last_char    (last_char),
		.bad_alphabet (bad_alphabet)
	);

endmodule

`default_nettype wire

### sim/tb_signed_integer_to_radix_text_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for signed_integer_to_radix_text_core: drives numbers under many
// alphabets, predicts the text beats of each one and checks them in order.
// Depends on radtxt_pkg and the core itself.

module tb_signed_integer_to_radix_text_core;
	import radtxt_pkg::*;

	localparam int MAX_RADIX  = 16;
	localparam int VALUE_BITS = 32;
	localparam int LONG_HOLD  = 300;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic signed [VALUE_BITS-1:0] NUM_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_BITS-1:0] NUM_MAX = 32'sh7FFF_FFFF;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
		logic              bad;
	} text_beat_t;

	typedef enum int {
		SPOIL_PLUS, SPOIL_MINUS, SPOIL_LOW, SPOIL_HIGH, SPOIL_TWIN, SPOIL_SHORT
	} spoil_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [VALUE_BITS-1:0] number = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [CHAR_W-1:0] character;
	logic last_char;
	logic bad_alphabet;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Local copy of the configuration, updated on every register beat
	logic [LEN_W-1:0] radix_len = '0;
	logic [CFG_DATA_W-1:0] alpha_lo = '0;
	logic [CFG_DATA_W-1:0] alpha_hi = '0;

	logic signed [VALUE_BITS-1:0] pending_numbers[$];
	text_beat_t expected_text[$];

	logic in_took = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;
	int send_idle_pct = 30;
	int recv_idle_pct = 30;
	bit calm = 1'b0;
	int hold_reqs = 0;
	int hold_served = 0;
	int hold_left = 0;

	int mismatches = 0;
	int numbers_taken = 0;
	int beats_checked = 0;
	int rejections = 0;
	int settings = 0;

	signed_integer_to_radix_text_core #(
		.MAX_RADIX (MAX_RADIX),
		.VALUE_BITS(VALUE_BITS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.number      (number),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.character   (character),
		.last_char   (last_char),
		.bad_alphabet(bad_alphabet),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [CHAR_W-1:0] alpha_char(input int k);
		if (k < 8)
			return alpha_lo[8*k +: 8];
		return alpha_hi[8*(k-8) +: 8];
	endfunction

	function automatic bit alphabet_valid();
		logic [CHAR_W-1:0] c;
		if (radix_len < 2 || radix_len > MAX_RADIX)
			return 1'b0;
		for (int a = 0; a < radix_len; a++) begin
			c = alpha_char(a);
			if (c < CH_LOW || c > CH_HIGH || c == CH_PLUS || c == CH_MINUS)
				return 1'b0;
			for (int b = a + 1; b < radix_len; b++)
				if (alpha_char(b) == c)
					return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic due(input logic [CHAR_W-1:0] ch, input logic last, input logic bad);
		text_beat_t beat;
		beat.ch = ch;
		beat.last = last;
		beat.bad = bad;
		expected_text.push_back(beat);
	endtask

	// Expected text of one number: sign, then digits most significant first; one error beat for a bad alphabet
	task automatic predict_text(input logic signed [VALUE_BITS-1:0] value);
		logic [VALUE_BITS-1:0] mag;
		logic [VALUE_BITS-1:0] radix;
		logic [DIGIT_W-1:0] digs[VALUE_BITS];
		int n;
		int d;
		if (!alphabet_valid()) begin
			due(CH_NONE, 1'b1, 1'b1);
			rejections++;
			return;
		end
		radix = VALUE_BITS'(radix_len);
		mag = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
		n = 0;
		do begin
			digs[n] = DIGIT_W'(mag % radix);
			n++;
			mag = mag / radix;
		end while (mag != 0 && n < VALUE_BITS);
		if (value[VALUE_BITS-1])
			due(CH_MINUS, 1'b0, 1'b0);
		for (d = n - 1; d >= 0; d--)
			due(alpha_char(digs[d]), d == 0, 1'b0);
	endtask

	// Sample both channels; predict on accepted inputs, check accepted outputs
	always @(posedge clk) begin
		text_beat_t want;
		text_beat_t got;
		in_took <= in_valid && !in_stall;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_text(number);
				numbers_taken++;
			end
			if (out_valid && !out_stall) begin
				got.ch = character;
				got.last = last_char;
				got.bad = bad_alphabet;
				if (expected_text.size() == 0) begin
					$display("%0t: unexpected beat: expected none, got char %h last %b bad %b",
						$time, got.ch, got.last, got.bad);
					mismatches++;
				end else begin
					want = expected_text.pop_front();
					beats_checked++;
					if (got !== want) begin
						$display("%0t: beat mismatch: expected char %h last %b bad %b, got char %h last %b bad %b",
							$time, want.ch, want.last, want.bad, got.ch, got.last, got.bad);
						mismatches++;
					end
				end
			end
		end
	end

	// Feed numbers; hold a stalled beat, otherwise idle in bursts or advance
	always @(negedge clk) begin
		if (in_valid && !in_took) begin
		end else if (send_gap != 0) begin
			in_valid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (pending_numbers.size() != 0) begin
			if (!calm && $urandom_range(99, 0) < send_idle_pct) begin
				in_valid <= 1'b0;
				send_gap <= $urandom_range(10, 0);
			end else begin
				in_valid <= 1'b1;
				number <= pending_numbers.pop_front();
			end
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Stall the output: long hold on request, otherwise random bursts
	always @(negedge clk) begin
		if (hold_served != hold_reqs) begin
			hold_served <= hold_reqs;
			hold_left <= LONG_HOLD;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (recv_gap != 0) begin
			recv_gap <= recv_gap - 1;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(99, 0) < recv_idle_pct) begin
			recv_gap <= $urandom_range(10, 0);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_RADIX_LENGTH:  radix_len = val[LEN_W-1:0];
			REG_ALPHABET_LOW:  alpha_lo = val;
			REG_ALPHABET_HIGH: alpha_hi = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_alphabet(input int len, input logic [ALPHA_W-1:0] chars);
		logic [CFG_DATA_W-1:0] len_word;
		len_word = {$urandom, $urandom};
		len_word[LEN_W-1:0] = LEN_W'(len);
		write_reg(REG_RADIX_LENGTH, len_word);
		write_reg(REG_ALPHABET_LOW, chars[63:0]);
		write_reg(REG_ALPHABET_HIGH, chars[127:64]);
		settings++;
	endtask

	function automatic logic [ALPHA_W-1:0] text_chars(input string s);
		logic [ALPHA_W-1:0] chars;
		chars = '0;
		for (int i = 0; i < s.len() && i < ALPHA_SLOTS; i++)
			chars[8*i +: 8] = s[i];
		return chars;
	endfunction

	// Random distinct legal characters; optionally break the alphabet one way
	task automatic pick_alphabet(input int len, input bit spoil);
		logic [ALPHA_W-1:0] chars;
		logic [CHAR_W-1:0] c;
		bit clash;
		int slot;
		chars = {$urandom, $urandom, $urandom, $urandom};
		for (int k = 0; k < len; k++) begin
			do begin
				c = CHAR_W'($urandom_range(127, 33));
				clash = (c == CH_PLUS) || (c == CH_MINUS);
				for (int j = 0; j < k; j++)
					if (chars[8*j +: 8] == c)
						clash = 1'b1;
			end while (clash);
			chars[8*k +: 8] = c;
		end
		if (spoil) begin
			slot = $urandom_range(len - 1, 0);
			case (spoil_t'($urandom_range(SPOIL_SHORT, SPOIL_PLUS)))
				SPOIL_PLUS:  chars[8*slot +: 8] = CH_PLUS;
				SPOIL_MINUS: chars[8*slot +: 8] = CH_MINUS;
				SPOIL_LOW:   chars[8*slot +: 8] = CHAR_W'($urandom_range(32, 0));
				SPOIL_HIGH:  chars[8*slot +: 8] = CHAR_W'($urandom_range(255, 128));
				SPOIL_TWIN:  chars[8*slot +: 8] = chars[8*((slot + 1) % len) +: 8];
				default:     len = $urandom_range(1, 0);
			endcase
		end
		load_alphabet(len, chars);
	endtask

	// Mix of full-range, short, and extreme values, either sign
	task automatic queue_random_numbers(input int count);
		logic signed [VALUE_BITS-1:0] v;
		for (int k = 0; k < count; k++) begin
			case ($urandom_range(3, 0))
				0: v = $urandom;
				1: v = $urandom_range(300, 0);
				2: v = $urandom >> $urandom_range(31, 0);
				default: begin
					case ($urandom_range(3, 0))
						0: v = NUM_MIN;
						1: v = NUM_MAX;
						2: v = -1;
						default: v = 0;
					endcase
				end
			endcase
			if (v != NUM_MIN && $urandom_range(1, 0))
				v = -v;
			pending_numbers.push_back(v);
		end
	endtask

	// Wait until every number is taken and every expected beat has come
	task automatic wait_idle();
		do @(posedge clk);
		while (pending_numbers.size() != 0 || in_valid || expected_text.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int len;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset alphabet has length zero: every number is rejected
		pending_numbers.push_back(0);
		pending_numbers.push_back(NUM_MIN);
		wait_idle();

		// Length one cannot form a radix
		load_alphabet(1, text_chars("0"));
		pending_numbers.push_back(7);
		wait_idle();

		// Decimal, with the spare register index written and ignored
		write_reg(REG_SPARE, {$urandom, $urandom});
		load_alphabet(10, text_chars("0123456789"));
		pending_numbers.push_back(0);      pending_numbers.push_back(1);
		pending_numbers.push_back(-1);     pending_numbers.push_back(10);
		pending_numbers.push_back(NUM_MAX); pending_numbers.push_back(NUM_MIN);
		pending_numbers.push_back(-98765);
		wait_idle();

		// Binary: most negative value gives the longest text
		load_alphabet(2, text_chars("01"));
		pending_numbers.push_back(NUM_MIN); pending_numbers.push_back(NUM_MAX);
		pending_numbers.push_back(-1);      pending_numbers.push_back(5);
		wait_idle();

		// Full sixteen-character alphabet reaches the high register
		load_alphabet(16, text_chars("0123456789ABCDEF"));
		pending_numbers.push_back(NUM_MIN); pending_numbers.push_back(32'sh1234_5678);
		pending_numbers.push_back(-1);
		wait_idle();

		// Boundary characters that are still legal
		load_alphabet(3, {104'd0, 8'd127, 8'd126, 8'd33});
		pending_numbers.push_back(-100); pending_numbers.push_back(8);
		wait_idle();

		// Broken alphabets: duplicate, plus, minus, too low, too high, bad last char
		load_alphabet(4, text_chars("0120"));
		pending_numbers.push_back(3);
		wait_idle();
		load_alphabet(2, text_chars("+1"));
		pending_numbers.push_back(3);
		wait_idle();
		load_alphabet(2, text_chars("0-"));
		pending_numbers.push_back(-3);
		wait_idle();
		load_alphabet(3, {104'd0, 8'd50, 8'd32, 8'd49});
		pending_numbers.push_back(9);
		wait_idle();
		load_alphabet(16, text_chars("0123456789ABCDE") | {8'd200, 120'd0});
		pending_numbers.push_back(9);
		wait_idle();
		load_alphabet(16, text_chars("0123456789ABCDE") | {8'h41, 120'd0});
		pending_numbers.push_back(-9);
		wait_idle();

		// Random alphabets, mostly legal
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: len = 2;
				1: len = MAX_RADIX;
				default: len = $urandom_range(MAX_RADIX, 2);
			endcase
			pick_alphabet(len, phase >= 2 && $urandom_range(3, 0) == 0);
			case ($urandom_range(2, 0))
				0: send_idle_pct = 0;
				1: send_idle_pct = 20;
				default: send_idle_pct = 50;
			endcase
			recv_idle_pct = $urandom_range(2, 0) * 25;
			if (phase == 7)
				calm = 1'b1;
			if (phase == 3)
				hold_reqs++;
			if (phase == 5) begin
				// Stop feeding until the block has drained, then resume
				queue_random_numbers(8);
				wait_idle();
				queue_random_numbers(9);
			end else begin
				queue_random_numbers(17);
			end
			wait_idle();
		end

		repeat (200) @(negedge clk);
		$display("Converted %0d numbers under %0d alphabet settings; %0d text beats checked.",
			numbers_taken, settings, beats_checked);
		$display("%0d of those conversions were rejected for a bad alphabet.", rejections);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

### filelist.f
hdl/radtxt_pkg.sv
hdl/radtxt_cfg.sv
hdl/radtxt_ctrl.sv
hdl/radtxt_dp.sv
hdl/signed_integer_to_radix_text_core.sv
sim/tb_signed_integer_to_radix_text_core.sv
